FILE: rtl/serial_line_editor_assert.svh
// Assertion macros for the checker of the line editor.
// Every property is sampled at the rising edge of clk and is off while
// arst_n is low.
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial_line_editor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial_line_editor: next-cycle check failed");

`endif

FILE: rtl/sle_pkg.sv
package sle_pkg;

	// Input kinds carried in the slave-side tuser bit.
	localparam logic OP_RX      = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Result channels carried in the master-side tuser bit.
	localparam logic CH_ECHO = 1'b0;
	localparam logic CH_MSG  = 1'b1;

	// Characters with a meaning of their own.
	localparam logic [7:0] K_CR     = 8'h0d;
	localparam logic [7:0] K_BS     = 8'h08;
	localparam logic [7:0] K_DOLLAR = 8'h24;
	localparam logic [7:0] K_ESC    = 8'h1b;
	localparam logic [7:0] K_BSLASH = 8'h5c;
	localparam logic [7:0] K_SLASH  = 8'h2f;
	localparam logic [7:0] K_NUL    = 8'h00;

endpackage

FILE: rtl/sle_ram.sv
module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/serial_line_editor.sv
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: rx_byte[7:0]   tuser: opcode
// m_axis    out        tdata: out_byte[7:0]  tuser: channel  tlast: last_of_run
//
// An input transfer is taken only while the sequencer is idle. A release or an
// ignored byte leaves it idle; any other item first emits its results, and a
// carriage return reads the line out until the index reaches the line length.
// The reset arst_n is asynchronous and active low; it clears the line and the
// pending message. The output register lets the next input transfer in while the
// last result waits, and a stalled m_axis simply holds the sequencer.
module serial_line_editor
	import sle_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // rx_byte[7:0]
	input  logic       s_axis_tuser,   // opcode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte[7:0]
	output logic       m_axis_tuser,   // channel
	output logic       m_axis_tlast    // last_of_run
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	// The sequencer walks one result per cycle through these steps unless m_axis
	// stalls; after an echo or an erase run it continues at the step in nxt_q.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ECHO,
		ST_ERASE,
		ST_MSG,
		ST_TERM_CHAR,
		ST_TERM0
	} state_t;

	state_t        state_q;
	state_t        nxt_q;
	logic          pending_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_d;
	logic [CW-1:0] idx_p1;
	logic [7:0]    c_q;
	logic [7:0]    rd_data;

	logic          acc;
	logic          out_free;
	logic          at_end;
	logic          erase_end;
	logic          line_full;
	logic          plain_char;
	logic          wr_en;

	logic          emit_en;
	logic          emit_ch;
	logic [7:0]    emit_byte;
	logic          emit_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// The one shared unit: an index that counts up and is compared with the
	// line length. It paces erase runs as well as the read-out of a message.
	assign idx_p1    = idx_q + CW'(1);
	assign at_end    = (idx_q == count_q);
	assign erase_end = (idx_p1 == count_q);
	assign line_full = (count_q >= CW'(LINE_DEPTH));

	// Any byte without a special meaning is stored when there is room and no message is pending.
	assign plain_char = (s_axis_tdata != K_CR) && (s_axis_tdata != K_BS) &&
		(s_axis_tdata != K_ESC) && (s_axis_tdata != K_DOLLAR) &&
		(s_axis_tdata != K_BSLASH) && (s_axis_tdata != K_SLASH);
	assign wr_en = acc && (s_axis_tuser == OP_RX) && !pending_q && plain_char && !line_full;

	// Result for the current step. A message step presents the stored byte at
	// idx_q; once the index reaches the line length it presents nothing.
	always_comb begin
		emit_en   = 1'b0;
		emit_ch   = CH_ECHO;
		emit_byte = c_q;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				emit_en = 1'b0;
			end
			ST_ECHO: begin
				emit_en   = out_free;
				emit_last = (nxt_q == ST_IDLE);
			end
			ST_ERASE: begin
				emit_en   = out_free;
				emit_byte = K_BS;
				emit_last = erase_end && (nxt_q == ST_IDLE);
			end
			ST_MSG: begin
				emit_en   = out_free && !at_end;
				emit_ch   = CH_MSG;
				emit_byte = rd_data;
			end
			ST_TERM_CHAR: begin
				emit_en = out_free;
				emit_ch = CH_MSG;
			end
			ST_TERM0: begin
				emit_en   = out_free;
				emit_ch   = CH_MSG;
				emit_byte = K_NUL;
				emit_last = 1'b1;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// The RAM is read at the next index, so its registered output always
	// shows the entry at idx_q.
	always_comb begin
		if (acc) begin
			idx_d = '0;
		end else if (emit_en && (state_q == ST_ERASE || state_q == ST_MSG)) begin
			idx_d = idx_p1;
		end else begin
			idx_d = idx_q;
		end
	end

	sle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (s_axis_tdata),
		.rd_addr (idx_d[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			nxt_q         <= ST_IDLE;
			pending_q     <= 1'b0;
			count_q       <= '0;
			idx_q         <= '0;
			c_q           <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= CH_ECHO;
			m_axis_tlast  <= 1'b0;
		end else begin
			idx_q <= idx_d;

			// Output register: loaded by the sequencer, emptied by the sink.
			if (emit_en) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= emit_byte;
				m_axis_tuser  <= emit_ch;
				m_axis_tlast  <= emit_last;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (s_axis_tuser == OP_RELEASE) begin
							pending_q <= 1'b0;
						end else if (!pending_q) begin
							c_q <= s_axis_tdata;
							unique case (s_axis_tdata)
								K_CR: begin
									// Echo, then the stored line and a terminator.
									pending_q <= 1'b1;
									nxt_q     <= ST_MSG;
									state_q   <= ST_ECHO;
								end
								K_BS: begin
									if (count_q != '0) begin
										count_q <= count_q - CW'(1);
										nxt_q   <= ST_IDLE;
										state_q <= ST_ECHO;
									end
								end
								K_ESC, K_DOLLAR: begin
									// Erase the line; a dollar then sends itself.
									if (s_axis_tdata == K_DOLLAR) begin
										pending_q <= 1'b1;
										nxt_q     <= ST_TERM_CHAR;
									end else begin
										nxt_q <= ST_IDLE;
									end
									if (count_q != '0) begin
										state_q <= ST_ERASE;
									end else if (s_axis_tdata == K_DOLLAR) begin
										state_q <= ST_TERM_CHAR;
									end
								end
								K_BSLASH, K_SLASH: begin
									count_q   <= '0;
									pending_q <= 1'b1;
									nxt_q     <= ST_TERM_CHAR;
									state_q   <= ST_ECHO;
								end
								default: begin
									if (!line_full) begin
										count_q <= count_q + CW'(1);
										nxt_q   <= ST_IDLE;
										state_q <= ST_ECHO;
									end
								end
							endcase
						end
					end
				end
				ST_ECHO: begin
					if (emit_en) begin
						state_q <= nxt_q;
					end
				end
				ST_ERASE: begin
					if (emit_en && erase_end) begin
						count_q <= '0;
						state_q <= nxt_q;
					end
				end
				ST_MSG: begin
					if (at_end) begin
						count_q <= '0;
						state_q <= ST_TERM0;
					end
				end
				ST_TERM_CHAR: begin
					if (emit_en) begin
						state_q <= ST_TERM0;
					end
				end
				ST_TERM0: begin
					if (emit_en) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sle_checker.sv
module sle_checker
	import sle_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tuser,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

`include "serial_line_editor_assert.svh"

	// A result that is not taken stays offered.
	`SLE_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// Every message closes with the zero terminator.
	`SLE_ASSERT_SAME(a_msg_ends_nul, m_axis_tvalid && m_axis_tuser == CH_MSG && m_axis_tlast, m_axis_tdata == K_NUL)

	// Echoes of line-ending characters are always followed by a message.
	`SLE_ASSERT_SAME(a_echo_then_msg, m_axis_tvalid && m_axis_tuser == CH_ECHO && (m_axis_tdata == K_CR || m_axis_tdata == K_SLASH || m_axis_tdata == K_BSLASH), !m_axis_tlast)

	// While an item still has results to come, no new input is taken.
	`SLE_ASSERT_SAME(a_busy_no_input, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);
